### src/prh_pkg.sv
// ----------------------------------------------------------------------------
// prh_pkg
// types, constants and the microcode table of the percentile rank histogram
// ----------------------------------------------------------------------------
package prh_pkg;

  // result and counter widths
  localparam int unsigned CNT_W   = 18;
  localparam int unsigned RATIO_W = 17;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned STEP_W  = 5;

  localparam logic [CNT_W-1:0]   CNT_MAX = '1;
  localparam logic [RATIO_W-1:0] ONE_Q16 = RATIO_W'(1) << FRAC_W;

  // operation codes of the input transaction
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // one quotient bit per divide step
  localparam int unsigned DIV_STEPS = FRAC_W;
  localparam int unsigned DIV_CW    = $clog2(DIV_STEPS);

  // microcode step addresses
  typedef enum logic [STEP_W-1:0] {
    S_CLEAR     = 5'd0,
    S_IDLE      = 5'd1,
    S_CHECK     = 5'd2,
    S_READ_USER = 5'd3,
    S_LATCH_OLD = 5'd4,
    S_READ_OLD  = 5'd5,
    S_FIX_OLD   = 5'd6,
    S_READ_NEW  = 5'd7,
    S_INC_NEW   = 5'd8,
    S_LATCH_P   = 5'd9,
    S_TEST_P    = 5'd10,
    S_SUM_FIRST = 5'd11,
    S_SUM_LOOP  = 5'd12,
    S_DIV_INIT  = 5'd13,
    S_DIV_CHECK = 5'd14,
    S_DIV_STEP  = 5'd15,
    S_SET_QUOT  = 5'd16,
    S_SET_ONE   = 5'd17,
    S_EMIT      = 5'd18,
    S_DONE      = 5'd19
  } step_t;

  // datapath action of one step
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_ACCEPT,
    ACT_LATCH_OLD,
    ACT_READ_OLD,
    ACT_FIX_OLD,
    ACT_READ_NEW,
    ACT_INC_NEW,
    ACT_LATCH_P,
    ACT_SUM_FIRST,
    ACT_SUM_LOOP,
    ACT_DIV_INIT,
    ACT_DIV_STEP,
    ACT_SET_QUOT,
    ACT_SET_ONE,
    ACT_EMIT
  } act_t;

  // jump condition, jump taken when true, else fall through
  typedef enum logic [3:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_CLR_BUSY,
    COND_NO_INPUT,
    COND_BAD_UPDATE,
    COND_IS_QUERY,
    COND_P_ZERO,
    COND_SUM_MORE,
    COND_ALONE,
    COND_BELOW_GE,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // control store
  function automatic ctrl_word_t ucode_fetch(step_t s);
    ctrl_word_t w;
    case (s)
      S_CLEAR:     w = '{ACT_CLEAR,     COND_CLR_BUSY,   S_CLEAR};
      S_IDLE:      w = '{ACT_ACCEPT,    COND_NO_INPUT,   S_IDLE};
      S_CHECK:     w = '{ACT_NONE,      COND_BAD_UPDATE, S_IDLE};
      S_READ_USER: w = '{ACT_NONE,      COND_IS_QUERY,   S_LATCH_P};
      S_LATCH_OLD: w = '{ACT_LATCH_OLD, COND_NONE,       S_IDLE};
      S_READ_OLD:  w = '{ACT_READ_OLD,  COND_NONE,       S_IDLE};
      S_FIX_OLD:   w = '{ACT_FIX_OLD,   COND_NONE,       S_IDLE};
      S_READ_NEW:  w = '{ACT_READ_NEW,  COND_NONE,       S_IDLE};
      S_INC_NEW:   w = '{ACT_INC_NEW,   COND_ALWAYS,     S_IDLE};
      S_LATCH_P:   w = '{ACT_LATCH_P,   COND_NONE,       S_IDLE};
      S_TEST_P:    w = '{ACT_NONE,      COND_P_ZERO,     S_EMIT};
      S_SUM_FIRST: w = '{ACT_SUM_FIRST, COND_NONE,       S_IDLE};
      S_SUM_LOOP:  w = '{ACT_SUM_LOOP,  COND_SUM_MORE,   S_SUM_LOOP};
      S_DIV_INIT:  w = '{ACT_DIV_INIT,  COND_ALONE,      S_SET_ONE};
      S_DIV_CHECK: w = '{ACT_NONE,      COND_BELOW_GE,   S_SET_ONE};
      S_DIV_STEP:  w = '{ACT_DIV_STEP,  COND_DIV_MORE,   S_DIV_STEP};
      S_SET_QUOT:  w = '{ACT_SET_QUOT,  COND_ALWAYS,     S_EMIT};
      S_SET_ONE:   w = '{ACT_SET_ONE,   COND_NONE,       S_IDLE};
      S_EMIT:      w = '{ACT_EMIT,      COND_OUT_BUSY,   S_EMIT};
      S_DONE:      w = '{ACT_NONE,      COND_ALWAYS,     S_IDLE};
      default:     w = '{ACT_NONE,      COND_ALWAYS,     S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### src/prh_ram.sv
// ----------------------------------------------------------------------------
// prh_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module prh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/percentile_rank_histogram.sv
// throughput: one item at a time, set by the bucket ram walked one entry per cycle
// and a 16-step serial fraction divide
// reset: a clearing pass over the larger ram's address range zeroes both rams
// ----------------------------------------------------------------------------
// percentile_rank_histogram
// per-user page counts, a users-per-page-count histogram and a rank query,
// driven by a microcoded sequencer over a small datapath and two rams
// ----------------------------------------------------------------------------
module percentile_rank_histogram
  import prh_pkg::*;
#(
  parameter int unsigned USER_SLOTS = 131072,
  parameter int unsigned PAGE_LIMIT = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [16:0]          user_id,
  input  logic [9:0]           pages_read,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RATIO_W-1:0]   ratio,
  output logic [CNT_W-1:0]     users_below,
  output logic [CNT_W-1:0]     other_users
);

  // address widths, the clearing pass covers the larger ram
  localparam int unsigned UW      = $clog2(USER_SLOTS);
  localparam int unsigned PW      = $clog2(PAGE_LIMIT);
  localparam int unsigned CLR_LEN = (USER_SLOTS > PAGE_LIMIT) ? USER_SLOTS : PAGE_LIMIT;
  localparam int unsigned CLW     = $clog2(CLR_LEN);

  // sequencer
  step_t      upc;
  step_t      upc_next;
  ctrl_word_t cw;
  logic       jump;

  // clearing pass counter
  logic [CLW-1:0] clr;

  // latched transaction
  logic          op_r;
  logic [16:0]   uid_r;
  logic          uid_ok;
  logic [PW-1:0] pc_r;

  // working registers
  logic [PW-1:0]     old_pages;
  logic [PW-1:0]     p;
  logic [PW-1:0]     idx;
  logic [CNT_W-1:0]  acc;
  logic [CNT_W-1:0]  seen_users;
  logic [CNT_W-1:0]  other_w;
  logic [RATIO_W-1:0] ratio_w;
  logic [CNT_W-1:0]  rem;
  logic [FRAC_W-1:0] quot;
  logic [DIV_CW-1:0] dcnt;

  // ram ports
  logic          user_we;
  logic [UW-1:0] user_waddr;
  logic [PW-1:0] user_wdata;
  logic [UW-1:0] user_raddr;
  logic [PW-1:0] user_rdata;

  logic             bkt_we;
  logic [PW-1:0]    bkt_waddr;
  logic [CNT_W-1:0] bkt_wdata;
  logic [PW-1:0]    bkt_raddr;
  logic [CNT_W-1:0] bkt_rdata;

  // datapath helpers
  logic             clear_user_en;
  logic             clear_bkt_en;
  logic             out_busy;
  logic [CNT_W:0]   acc_sum;
  logic [CNT_W:0]   rem2;
  logic             rem_ge;
  logic [CNT_W-1:0] bkt_dec;
  logic [CNT_W-1:0] bkt_inc;

  assign cw = ucode_fetch(upc);

  // one transaction per visit to the idle step
  assign in_stall = (cw.act != ACT_ACCEPT);
  assign out_busy = out_valid && out_stall;

  assign clear_user_en = (32'(clr) < USER_SLOTS);
  assign clear_bkt_en  = (32'(clr) < PAGE_LIMIT);

  // saturating sum of buckets and divider compare
  assign acc_sum = {1'b0, acc} + {1'b0, bkt_rdata};
  assign rem2    = {rem, 1'b0};
  assign rem_ge  = (rem2 >= {1'b0, other_w});
  assign bkt_dec = (bkt_rdata == '0) ? '0 : bkt_rdata - CNT_W'(1);
  assign bkt_inc = (bkt_rdata == CNT_MAX) ? CNT_MAX : bkt_rdata + CNT_W'(1);

  // jump condition select
  always_comb begin
    case (cw.cond)
      COND_NONE:       jump = 1'b0;
      COND_ALWAYS:     jump = 1'b1;
      COND_CLR_BUSY:   jump = (clr != CLW'(CLR_LEN - 1));
      COND_NO_INPUT:   jump = !in_valid;
      COND_BAD_UPDATE: jump = (op_r == OP_UPDATE) && !uid_ok;
      COND_IS_QUERY:   jump = (op_r == OP_QUERY);
      COND_P_ZERO:     jump = (p == '0);
      COND_SUM_MORE:   jump = (idx < p);
      COND_ALONE:      jump = (seen_users <= CNT_W'(1));
      COND_BELOW_GE:   jump = (acc >= other_w);
      COND_DIV_MORE:   jump = (dcnt != DIV_CW'(DIV_STEPS - 1));
      COND_OUT_BUSY:   jump = out_busy;
      default:         jump = 1'b0;
    endcase
    upc_next = jump ? cw.target : step_t'(upc + STEP_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_CLEAR;
    end else begin
      upc <= upc_next;
    end
  end

  // user table ports: read always at the latched user, written on clear and update
  always_comb begin
    user_raddr = UW'(uid_r);
    user_we    = 1'b0;
    user_waddr = UW'(uid_r);
    user_wdata = pc_r;
    case (cw.act)
      ACT_CLEAR: begin
        user_we    = clear_user_en;
        user_waddr = clr[UW-1:0];
        user_wdata = '0;
      end
      ACT_READ_OLD: begin
        user_we = 1'b1;
      end
      default: begin
        user_we = 1'b0;
      end
    endcase
  end

  // histogram ports
  always_comb begin
    bkt_raddr = idx;
    bkt_we    = 1'b0;
    bkt_waddr = pc_r;
    bkt_wdata = bkt_inc;
    case (cw.act)
      ACT_CLEAR: begin
        bkt_we    = clear_bkt_en;
        bkt_waddr = clr[PW-1:0];
        bkt_wdata = '0;
      end
      ACT_READ_OLD: begin
        bkt_raddr = old_pages;
      end
      ACT_FIX_OLD: begin
        // a known user leaves the old bucket
        bkt_we    = (old_pages != '0);
        bkt_waddr = old_pages;
        bkt_wdata = bkt_dec;
      end
      ACT_READ_NEW: begin
        bkt_raddr = pc_r;
      end
      ACT_INC_NEW: begin
        bkt_we = 1'b1;
      end
      default: begin
        bkt_we = 1'b0;
      end
    endcase
  end

  prh_ram #(
    .WIDTH (PW),
    .DEPTH (USER_SLOTS)
  ) u_user_ram (
    .clk   (clk),
    .we    (user_we),
    .waddr (user_waddr),
    .wdata (user_wdata),
    .raddr (user_raddr),
    .rdata (user_rdata)
  );

  prh_ram #(
    .WIDTH (CNT_W),
    .DEPTH (PAGE_LIMIT)
  ) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (bkt_raddr),
    .rdata (bkt_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr        <= '0;
      seen_users <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cw.act == ACT_CLEAR && clr != CLW'(CLR_LEN - 1)) begin
        clr <= clr + CLW'(1);
      end
      // a user never seen before joins the population
      if (cw.act == ACT_FIX_OLD && old_pages == '0 && seen_users != CNT_MAX) begin
        seen_users <= seen_users + CNT_W'(1);
      end
      if (cw.act == ACT_EMIT && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (cw.act)
      ACT_ACCEPT: begin
        if (in_valid) begin
          op_r   <= op;
          uid_r  <= user_id;
          uid_ok <= (32'(user_id) < USER_SLOTS);
          // page counts past the top bucket land in the top bucket
          pc_r   <= (32'(pages_read) >= PAGE_LIMIT) ? PW'(PAGE_LIMIT - 1) : PW'(pages_read);
        end
      end
      ACT_LATCH_OLD: begin
        old_pages <= user_rdata;
      end
      ACT_LATCH_P: begin
        // an unknown user index reads as unseen
        p       <= uid_ok ? user_rdata : '0;
        acc     <= '0;
        idx     <= '0;
        ratio_w <= '0;
        other_w <= '0;
      end
      ACT_SUM_FIRST: begin
        idx <= idx + PW'(1);
      end
      ACT_SUM_LOOP: begin
        // bucket data trails the read address by one step
        acc <= acc_sum[CNT_W] ? CNT_MAX : acc_sum[CNT_W-1:0];
        idx <= idx + PW'(1);
      end
      ACT_DIV_INIT: begin
        other_w <= (seen_users <= CNT_W'(1)) ? '0 : seen_users - CNT_W'(1);
        rem     <= acc;
        quot    <= '0;
        dcnt    <= '0;
      end
      ACT_DIV_STEP: begin
        // restoring divide, below < other so every quotient bit is fractional
        if (rem_ge) begin
          rem <= CNT_W'(rem2 - {1'b0, other_w});
        end else begin
          rem <= rem2[CNT_W-1:0];
        end
        quot <= {quot[FRAC_W-2:0], rem_ge};
        dcnt <= dcnt + DIV_CW'(1);
      end
      ACT_SET_QUOT: begin
        ratio_w <= {1'b0, quot};
      end
      ACT_SET_ONE: begin
        ratio_w <= ONE_Q16;
      end
      ACT_EMIT: begin
        if (!out_busy) begin
          ratio       <= ratio_w;
          users_below <= acc;
          other_users <= other_w;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // the fraction never exceeds one
  a_ratio_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ratio <= ONE_Q16))
    else $error("ratio above one");

  // with no divisor the answer is either unseen or alone
  a_no_divisor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && other_users == '0) |-> (ratio == '0 || ratio == ONE_Q16))
    else $error("ratio without divisor");

  // nobody below means rank zero when there is a divisor
  a_zero_below: assert property (@(posedge clk) disable iff (rst)
    (out_valid && other_users != '0 && users_below == '0) |-> (ratio == '0))
    else $error("nonzero ratio with no users below");

  // the population only grows
  a_seen_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (seen_users >= $past(seen_users)))
    else $error("seen user count went down");

  // no transaction is taken during the clearing pass
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    (upc == S_CLEAR) |-> (in_stall && !out_valid))
    else $error("activity during clearing pass");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// percentile rank histogram testbench
// drives page count updates and rank queries through the valid/stall input
// channel and checks every rank result against a built-in histogram predictor or a typed value,
// first from a short directed table, then random traffic under several idling
// mixes and one long result hold-off
// ----------------------------------------------------------------------------
module testbench
  import prh_pkg::*;
();

  localparam int unsigned USERS       = 131072;
  localparam int unsigned PAGES       = 1024;
  localparam int unsigned POOL_SIZE   = 24;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned DRAIN_LIMIT = 20000;
  // quiet wait, longer than the longest query
  localparam int unsigned QUIET_CYCLES = 1200;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [CNT_W-1:0]   below;
    logic [CNT_W-1:0]   other;
  } rank_t;

  typedef struct {
    logic         kind;
    logic [16:0]  uid;
    logic [9:0]   pages;
    bit           typed;
    rank_t        want;
  } probe_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 op;
  logic [16:0]          user_id;
  logic [9:0]           pages_read;
  logic                 out_valid;
  logic                 out_stall;
  logic [RATIO_W-1:0]   ratio;
  logic [CNT_W-1:0]     users_below;
  logic [CNT_W-1:0]     other_users;

  percentile_rank_histogram dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .user_id     (user_id),
    .pages_read  (pages_read),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ratio       (ratio),
    .users_below (users_below),
    .other_users (other_users)
  );

  // predictor state: stored pages per user, users per page count, users seen
  logic [9:0]       user_tally   [USERS];
  logic [CNT_W-1:0] bucket_tally [PAGES];
  logic [CNT_W-1:0] seen_total;

  // rank results still owed by the block, oldest first
  rank_t expected_ranks [$];

  probe_row_t  directed_rows [24];
  logic [16:0] user_pool [POOL_SIZE];

  int err_count;
  int n_updates;
  int n_queries;
  int n_unseen;
  int n_lone;

  // idling mix of the current phase, in percent
  int sender_idle_pct;
  int recv_stall_pct;

  // long hold-off of the result channel, counted by the receiver itself
  bit long_hold_req;
  int hold_count;

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // generous run limit, far above the slowest legal run
  initial begin
    #80_000_000;
    $display("timeout: %0d rank results still pending", expected_ranks.size());
    $display("Verification failed");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // an update moves the user out of the old bucket, or counts a new user when
  // the stored count is zero (zero pages leaves the user unseen)
  task automatic record_pages(input logic [16:0] uid, input logic [9:0] pc);
    logic [9:0] old;
    old = user_tally[uid];
    if (old != '0) begin
      if (bucket_tally[old] != '0) bucket_tally[old] = bucket_tally[old] - 1'b1;
    end else if (seen_total != CNT_MAX) begin
      seen_total = seen_total + 1'b1;
    end
    user_tally[uid] = pc;
    if (bucket_tally[pc] != CNT_MAX) bucket_tally[pc] = bucket_tally[pc] + 1'b1;
  endtask

  // sum of the buckets below the user's count, other users and Q1.16 ratio
  function automatic rank_t compute_rank(input logic [16:0] uid);
    rank_t             r;
    logic [9:0]        p;
    longint unsigned   sum;
    longint unsigned   quot;
    r = '0;
    p = user_tally[uid];
    if (p != '0) begin
      sum = 0;
      for (int i = 0; i < int'(p); i++) sum += bucket_tally[i];
      if (sum > CNT_MAX) sum = CNT_MAX;
      r.below = sum[CNT_W-1:0];
      if (seen_total <= 1) begin
        r.ratio = ONE_Q16;
      end else begin
        r.other = seen_total - 1'b1;
        quot = (sum << FRAC_W) / (longint'(seen_total) - 1);
        if (quot > ONE_Q16) quot = ONE_Q16;
        r.ratio = quot[RATIO_W-1:0];
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic offer_item(input logic kind, input logic [16:0] uid,
                            input logic [9:0] pc, input bit typed, input rank_t want);
    rank_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    op         = kind;
    user_id    = uid;
    pages_read = pc;
    do @(posedge clk); while (in_stall !== 1'b0);
    // transaction taken at this edge
    if (kind == OP_UPDATE) begin
      record_pages(uid, pc);
      n_updates++;
    end else begin
      predicted = typed ? want : compute_rank(uid);
      expected_ranks.push_back(predicted);
      n_queries++;
      if (predicted.other == '0 && predicted.ratio == '0) n_unseen++;
      if (predicted.other == '0 && predicted.ratio == ONE_Q16) n_lone++;
    end
    @(negedge clk);
  endtask

  // mostly a pool of recurring users so queries find history, some noise ids;
  // page counts mostly small to keep the bucket walk short
  task automatic random_item();
    logic [16:0] uid;
    logic [9:0]  pc;
    logic        kind;
    int          roll;
    roll = $urandom_range(99);
    uid  = (roll < 6) ? 17'($urandom) : user_pool[$urandom_range(POOL_SIZE - 1)];
    kind = ($urandom_range(99) < 45) ? OP_QUERY : OP_UPDATE;
    roll = $urandom_range(99);
    if (kind == OP_QUERY || roll < 10) pc = 10'($urandom);
    else if (roll < 22)                pc = '0;
    else                               pc = 10'($urandom_range(48, 1));
    offer_item(kind, uid, pc, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall driven at the falling edge
  // ---------------------------------------------------------------------------
  initial begin
    out_stall  = 1'b0;
    hold_count = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req && hold_count < HOLD_CYCLES) begin
        // hold the result channel so the block backs up into its input
        out_stall = 1'b1;
        hold_count++;
      end else begin
        out_stall = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // each result transaction is compared against the oldest expectation
  always @(posedge clk) begin : result_check
    rank_t head;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_ranks.size() == 0) begin
        flag_error($sformatf("result with nothing pending: ratio %0d below %0d other %0d",
                             ratio, users_below, other_users));
      end else begin
        head = expected_ranks.pop_front();
        if (ratio !== head.ratio)
          flag_error($sformatf("ratio %0d, expected %0d", ratio, head.ratio));
        if (users_below !== head.below)
          flag_error($sformatf("users_below %0d, expected %0d", users_below, head.below));
        if (other_users !== head.other)
          flag_error($sformatf("other_users %0d, expected %0d", other_users, head.other));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int drain_cycles;

    rst             = 1'b1;
    in_valid        = 1'b0;
    op              = OP_UPDATE;
    user_id         = '0;
    pages_read      = '0;
    err_count       = 0;
    n_updates       = 0;
    n_queries       = 0;
    n_unseen        = 0;
    n_lone          = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    long_hold_req   = 1'b0;

    // model starts cleared, like the block after its clearing pass
    for (int i = 0; i < int'(USERS); i++) user_tally[i] = '0;
    for (int i = 0; i < int'(PAGES); i++) bucket_tally[i] = '0;
    seen_total = '0;

    user_pool[0] = 17'd0;
    user_pool[1] = 17'h1FFFF;
    user_pool[2] = 17'd5;
    for (int i = 3; i < int'(POOL_SIZE); i++) user_pool[i] = 17'($urandom);

    // directed rows: typed results where they are obvious, the rest predicted
    directed_rows = '{
      // unseen users right after reset, page field ignored on a query
      '{OP_QUERY,  17'd0,      10'd0,    1'b1, '{17'd0, 18'd0, 18'd0}},
      '{OP_QUERY,  17'h1FFFF,  10'h3FF,  1'b1, '{17'd0, 18'd0, 18'd0}},
      // a lone user at the top page count
      '{OP_UPDATE, 17'd5,      10'h3FF,  1'b0, '{17'd0, 18'd0, 18'd0}},
      '{OP_QUERY,  17'd5,      10'd0,    1'b1, '{ONE_Q16, 18'd0, 18'd0}},
      // second user at one page, nobody below it
      '{OP_UPDATE, 17'h1FFFF,  10'd1,    1'b0, '{17'd0, 18'd0, 18'd0}},
      '{OP_QUERY,  17'h1FFFF,  10'd0,    1'b1, '{17'd0, 18'd0, 18'd1}},
      '{OP_QUERY,  17'd5,      10'd0,    1'b1, '{ONE_Q16, 18'd1, 18'd1}},
      // zero pages keeps the user unseen and counts it again next time
      '{OP_UPDATE, 17'd0,      10'd0,    1'b0, '{17'd0, 18'd0, 18'd0}},
      '{OP_QUERY,  17'd0,      10'd0,    1'b1, '{17'd0, 18'd0, 18'd0}},
      '{OP_UPDATE, 17'd0,      10'd0,    1'b0, '{17'd0, 18'd0, 18'd0}},
      '{OP_QUERY,  17'd5,      10'd0,    1'b0, '{17'd0, 18'd0, 18'd0}},
      '{OP_UPDATE, 17'd0,      10'd512,  1'b0, '{17'd0, 18'd0, 18'd0}},
      '{OP_QUERY,  17'd0,      10'd0,    1'b0, '{17'd0, 18'd0, 18'd0}},
      // moves between buckets
      '{OP_UPDATE, 17'd5,      10'd2,    1'b0, '{17'd0, 18'd0, 18'd0}},
      '{OP_QUERY,  17'd5,      10'd0,    1'b0, '{17'd0, 18'd0, 18'd0}},
      '{OP_UPDATE, 17'h1FFFF,  10'h3FF,  1'b0, '{17'd0, 18'd0, 18'd0}},
      '{OP_QUERY,  17'h1FFFF,  10'd0,    1'b0, '{17'd0, 18'd0, 18'd0}},
      // alternating bit patterns on id and page count
      '{OP_UPDATE, 17'h15555,  10'h155,  1'b0, '{17'd0, 18'd0, 18'd0}},
      '{OP_UPDATE, 17'h0AAAA,  10'h2AA,  1'b0, '{17'd0, 18'd0, 18'd0}},
      '{OP_QUERY,  17'h15555,  10'h2AA,  1'b0, '{17'd0, 18'd0, 18'd0}},
      '{OP_QUERY,  17'h0AAAA,  10'h155,  1'b0, '{17'd0, 18'd0, 18'd0}},
      // a seen user dropped back to zero pages reads as unseen
      '{OP_UPDATE, 17'h0AAAA,  10'd0,    1'b0, '{17'd0, 18'd0, 18'd0}},
      '{OP_QUERY,  17'h0AAAA,  10'd0,    1'b1, '{17'd0, 18'd0, 18'd0}},
      '{OP_QUERY,  17'h1FFFF,  10'd0,    1'b0, '{17'd0, 18'd0, 18'd0}}
    };

    // hold reset, the block then clears its rams on its own
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      offer_item(directed_rows[i].kind, directed_rows[i].uid, directed_rows[i].pages,
                 directed_rows[i].typed, directed_rows[i].want);

    // no idling, with one long result hold-off at the start
    long_hold_req = 1'b1;
    repeat (130) random_item();

    sender_idle_pct = 47;
    recv_stall_pct  = 0;
    repeat (130) random_item();

    sender_idle_pct = 0;
    recv_stall_pct  = 47;
    repeat (130) random_item();

    sender_idle_pct = 35;
    recv_stall_pct  = 35;
    repeat (126) random_item();

    in_valid = 1'b0;

    // let the outstanding results come home, then watch for strays
    drain_cycles = 0;
    while (expected_ranks.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (QUIET_CYCLES) @(posedge clk);
    if (expected_ranks.size() != 0)
      flag_error($sformatf("%0d rank results never arrived", expected_ranks.size()));

    $display("ran %0d page updates and %0d rank queries (%0d for unseen users, %0d lone)",
             n_updates, n_queries, n_unseen, n_lone);
    $display("idling mixes: none with a %0d-cycle result hold-off, sender, receiver, both",
             HOLD_CYCLES);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### percentile_rank_histogram.f
src/prh_pkg.sv
src/prh_ram.sv
src/percentile_rank_histogram.sv
verif/testbench.sv
